@@ hdl/sha256_pkg.sv @@
// Shared types, round constants and helper functions for the SHA-256 hasher.
package sha256_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  bytes_valid;
    logic        final_word;
  } sha256_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } sha256_out_t;

  typedef struct packed {
    logic load_in;
    logic load_mark;
    logic load_zero;
    logic load_len_hi;
    logic load_len_lo;
    logic push;
    logic round;
    logic add;
    logic out_shift;
    logic clear;
  } sha256_cmd_t;

  typedef struct packed {
    logic pend_done;
    logic blk_full;
    logic pend_empty;
    logic fill_at_len;
    logic round_last;
    logic out_last;
  } sha256_sts_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PUSH,
    S_COMP,
    S_ADD,
    S_OUT
  } sha256_state_t;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_MARK,
    PH_ZERO,
    PH_LEN_LO,
    PH_DIGEST
  } sha256_phase_t;

  localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
  localparam logic [5:0]  LEN_FILL  = 6'd56;
  localparam logic [2:0]  WORD_BYTES = 3'd4;

  localparam logic [31:0] INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

@@ hdl/sha256_dp.sv @@
// Datapath: byte packing, block buffer and schedule, round logic, chain value.
module sha256_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256_pkg::sha256_in_t  in_data,
  input  sha256_pkg::sha256_cmd_t cmd,
  output sha256_pkg::sha256_sts_t sts,
  output sha256_pkg::sha256_out_t out_data
);

  logic [31:0] chain_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] acc_r;
  logic [31:0] pend_r;
  logic [2:0]  cnt_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  round_r;
  logic [2:0]  oidx_r;

  logic [1:0]  off;
  logic [2:0]  room;
  logic [2:0]  take;
  logic        word_done;
  logic [31:0] acc_nxt;
  logic [31:0] pend_nxt;
  logic [5:0]  fill_nxt;
  logic [2:0]  in_cnt;
  logic [31:0] in_mask;
  logic [31:0] sched;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    off       = fill_r[1:0];
    room      = sha256_pkg::WORD_BYTES - {1'b0, off};
    take      = (cnt_r < room) ? cnt_r : room;
    word_done = (take == room);
    acc_nxt   = ((off == 2'd0) ? 32'd0 : acc_r) | (pend_r >> {off, 3'b000});
    pend_nxt  = pend_r << {take, 3'b000};
    fill_nxt  = fill_r + {3'd0, take};
    in_cnt    = (in_data.bytes_valid > sha256_pkg::WORD_BYTES) ? sha256_pkg::WORD_BYTES
                                                              : in_data.bytes_valid;
    in_mask   = ~(32'hffff_ffff >> {in_cnt, 3'b000});
  end

  always_comb begin
    sched = sha256_pkg::small_sigma1(w_r[14]) + w_r[9] + sha256_pkg::small_sigma0(w_r[1])
          + w_r[0];
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sha256_pkg::big_sigma1(v_r[4]) + ch + sha256_pkg::ROUND_K[round_r]
          + w_r[0];
    t2    = sha256_pkg::big_sigma0(v_r[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha256_pkg::INIT_CHAIN[i];
        v_r[i]     <= sha256_pkg::INIT_CHAIN[i];
      end
      cnt_r   <= 3'd0;
      fill_r  <= 6'd0;
      bits_r  <= 64'd0;
      round_r <= 6'd0;
      oidx_r  <= 3'd0;
    end else begin
      if (cmd.push) begin
        fill_r <= fill_nxt;
      end
      if (cmd.load_in) begin
        cnt_r  <= in_cnt;
        bits_r <= bits_r + {58'd0, in_cnt, 3'b000};
      end else if (cmd.load_mark) begin
        cnt_r <= 3'd1;
      end else if (cmd.load_zero) begin
        cnt_r <= room;
      end else if (cmd.load_len_hi || cmd.load_len_lo) begin
        cnt_r <= sha256_pkg::WORD_BYTES;
      end else if (cmd.push) begin
        cnt_r <= cnt_r - take;
      end
      if (cmd.round) begin
        for (int i = 1; i < 8; i++) begin
          if (i != 4) begin
            v_r[i] <= v_r[i-1];
          end
        end
        v_r[4]  <= v_r[3] + t1;
        v_r[0]  <= t1 + t2;
        round_r <= round_r + 6'd1;
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + v_r[i];
          v_r[i]     <= chain_r[i] + v_r[i];
        end
      end
      if (cmd.out_shift) begin
        for (int i = 0; i < 7; i++) begin
          chain_r[i] <= chain_r[i+1];
        end
        chain_r[7] <= chain_r[0];
        oidx_r     <= oidx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (word_done) begin
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[15] <= acc_nxt;
      end else begin
        acc_r <= acc_nxt;
      end
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= sched;
    end
    if (cmd.load_in) begin
      pend_r <= in_data.message_word & in_mask;
    end else if (cmd.load_mark) begin
      pend_r <= sha256_pkg::PAD_WORD;
    end else if (cmd.load_zero) begin
      pend_r <= 32'd0;
    end else if (cmd.load_len_hi) begin
      pend_r <= bits_r[63:32];
    end else if (cmd.load_len_lo) begin
      pend_r <= bits_r[31:0];
    end else if (cmd.push) begin
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    sts.pend_done   = (take == cnt_r);
    sts.blk_full    = word_done && (fill_r[5:2] == 4'hf);
    sts.pend_empty  = (cnt_r == 3'd0);
    sts.fill_at_len = (fill_r == sha256_pkg::LEN_FILL);
    sts.round_last  = (round_r == 6'd63);
    sts.out_last    = (oidx_r == 3'd7);
    out_data.digest_word = chain_r[0];
    out_data.digest_last = (oidx_r == 3'd7);
  end

endmodule

@@ hdl/sha256_ctrl.sv @@
// Controller: sequences word transfers, padding, compression rounds and digest output.
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_final,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  sha256_pkg::sha256_sts_t  sts,
  output sha256_pkg::sha256_cmd_t  cmd
);

  sha256_pkg::sha256_state_t state_r, state_nxt;
  sha256_pkg::sha256_phase_t ph_r, ph_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256_pkg::S_LOAD;
      ph_r    <= sha256_pkg::PH_DATA;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    if (accept) begin
      ph_nxt = in_final ? sha256_pkg::PH_MARK : sha256_pkg::PH_DATA;
    end
    unique case (state_r)
      sha256_pkg::S_LOAD: begin
        unique case (ph_r)
          sha256_pkg::PH_DATA: begin
            if (accept) begin
              state_nxt = sha256_pkg::S_PUSH;
            end
          end
          sha256_pkg::PH_MARK: begin
            state_nxt = sha256_pkg::S_PUSH;
            ph_nxt    = sha256_pkg::PH_ZERO;
          end
          sha256_pkg::PH_ZERO: begin
            state_nxt = sha256_pkg::S_PUSH;
            if (sts.fill_at_len) begin
              ph_nxt = sha256_pkg::PH_LEN_LO;
            end
          end
          sha256_pkg::PH_LEN_LO: begin
            state_nxt = sha256_pkg::S_PUSH;
            ph_nxt    = sha256_pkg::PH_DIGEST;
          end
          sha256_pkg::PH_DIGEST: begin
            state_nxt = sha256_pkg::S_OUT;
          end
          default: begin
            state_nxt = sha256_pkg::S_LOAD;
          end
        endcase
      end
      sha256_pkg::S_PUSH: begin
        if (sts.blk_full) begin
          state_nxt = sha256_pkg::S_COMP;
        end else if (accept) begin
          state_nxt = sha256_pkg::S_PUSH;
        end else if (sts.pend_done) begin
          state_nxt = sha256_pkg::S_LOAD;
        end
      end
      sha256_pkg::S_COMP: begin
        if (sts.round_last) begin
          state_nxt = sha256_pkg::S_ADD;
        end
      end
      sha256_pkg::S_ADD: begin
        state_nxt = sts.pend_empty ? sha256_pkg::S_LOAD : sha256_pkg::S_PUSH;
      end
      sha256_pkg::S_OUT: begin
        if (out_ready && sts.out_last) begin
          state_nxt = sha256_pkg::S_LOAD;
          ph_nxt    = sha256_pkg::PH_DATA;
        end
      end
      default: begin
        state_nxt = sha256_pkg::S_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sha256_pkg::S_LOAD: begin
        unique case (ph_r)
          sha256_pkg::PH_DATA:   in_ready = 1'b1;
          sha256_pkg::PH_MARK:   cmd.load_mark = 1'b1;
          sha256_pkg::PH_ZERO: begin
            if (sts.fill_at_len) begin
              cmd.load_len_hi = 1'b1;
            end else begin
              cmd.load_zero = 1'b1;
            end
          end
          sha256_pkg::PH_LEN_LO: cmd.load_len_lo = 1'b1;
          default: begin
          end
        endcase
      end
      sha256_pkg::S_PUSH: begin
        cmd.push = 1'b1;
        in_ready = (ph_r == sha256_pkg::PH_DATA) && sts.pend_done && !sts.blk_full;
      end
      sha256_pkg::S_COMP: begin
        cmd.round = 1'b1;
      end
      sha256_pkg::S_ADD: begin
        cmd.add = 1'b1;
      end
      sha256_pkg::S_OUT: begin
        out_valid     = 1'b1;
        cmd.out_shift = out_ready;
        cmd.clear     = out_ready && sts.out_last;
      end
      default: begin
      end
    endcase
    cmd.load_in = in_valid && in_ready;
  end

endmodule

@@ hdl/sha256_message_hasher.sv @@
// Top level of the streaming SHA-256 message hasher.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    message_word, bytes_valid, final_word
//   out_     output     out_valid / out_ready  digest_word, digest_last
//
// A message word goes through the byte packer, which splits a word whose bytes straddle
// a buffer word across both; each full 64-byte block then takes 64 rounds of the
// single round unit plus the chain add.
// The last word adds padding and length pushes, up to two block compressions,
// and eight digest word transfers.
// rst_n is synchronous, active low, and loads the initial hash values.
// Input stalls hold the packer; output stalls hold the digest word in place.
module sha256_message_hasher (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sha256_pkg::sha256_in_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha256_pkg::sha256_out_t out_data
);

  sha256_pkg::sha256_cmd_t cmd;
  sha256_pkg::sha256_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_data.final_word),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha256_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
